/* rtl/lh32_pkg.sv */
// Shared types, constants and the mixing-row function of the lookup2 hash block.
`timescale 1ns / 1ps

package lh32_pkg;

    localparam logic [31:0] GOLDEN_RATIO = 32'h9e37_79b9;
    localparam int unsigned BLOCK_BYTES  = 12;
    localparam int unsigned TAIL_BYTES   = BLOCK_BYTES - 1;
    localparam int unsigned MIX_ROWS     = 9;
    localparam int unsigned FILL_W       = $clog2(BLOCK_BYTES);
    localparam int unsigned ROW_W        = $clog2(MIX_ROWS);

    localparam logic [FILL_W-1:0] LAST_SLOT = FILL_W'(BLOCK_BYTES - 1);

    // Row codes of the mix, three rows per mixing word
    localparam logic [ROW_W-1:0] ROW_A0 = ROW_W'(0);
    localparam logic [ROW_W-1:0] ROW_B0 = ROW_W'(1);
    localparam logic [ROW_W-1:0] ROW_C0 = ROW_W'(2);
    localparam logic [ROW_W-1:0] ROW_A1 = ROW_W'(3);
    localparam logic [ROW_W-1:0] ROW_B1 = ROW_W'(4);
    localparam logic [ROW_W-1:0] ROW_C1 = ROW_W'(5);
    localparam logic [ROW_W-1:0] ROW_A2 = ROW_W'(6);
    localparam logic [ROW_W-1:0] ROW_B2 = ROW_W'(7);
    localparam logic [ROW_W-1:0] ROW_C2 = ROW_W'(8);

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } words_t;

    // One operation travelling down the mix pipeline
    typedef struct packed {
        logic   is_last;
        words_t w;
    } mix_op_t;

    // What the byte gatherer tells the control about the offered item
    typedef struct packed {
        logic   blk_done;
        words_t blk;
        words_t tail;
        logic   fresh;
    } gather_t;

    function automatic words_t add_words(input words_t x, input words_t y);
        words_t r;
        r.a = x.a + y.a;
        r.b = x.b + y.b;
        r.c = x.c + y.c;
        return r;
    endfunction

    function automatic words_t mix_row(input words_t w, input logic [ROW_W-1:0] row);
        words_t r;
        r = w;
        unique case (row)
            ROW_A0: r.a = (w.a - w.b - w.c) ^ (w.c >> 13);
            ROW_B0: r.b = (w.b - w.c - w.a) ^ (w.a << 8);
            ROW_C0: r.c = (w.c - w.a - w.b) ^ (w.b >> 13);
            ROW_A1: r.a = (w.a - w.b - w.c) ^ (w.c >> 12);
            ROW_B1: r.b = (w.b - w.c - w.a) ^ (w.a << 16);
            ROW_C1: r.c = (w.c - w.a - w.b) ^ (w.b >> 5);
            ROW_A2: r.a = (w.a - w.b - w.c) ^ (w.c >> 3);
            ROW_B2: r.b = (w.b - w.c - w.a) ^ (w.a << 10);
            ROW_C2: r.c = (w.c - w.a - w.b) ^ (w.b >> 15);
            default: r = w;
        endcase
        return r;
    endfunction

endpackage

/* rtl/lh32_gather.sv */
// Byte gatherer: partial block buffer, fill count, key length, block and tail words.
`timescale 1ns / 1ps

module lh32_gather (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              acc,
    input  logic [7:0]        key_byte,
    input  logic              byte_valid,
    input  logic              last,
    output lh32_pkg::gather_t info
);
    import lh32_pkg::*;

    logic [7:0]        buf_reg [0:TAIL_BYTES-1];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [31:0]       len_reg;
    logic [31:0]       len_next;
    logic [7:0]        merged [0:TAIL_BYTES-1];
    logic [7:0]        tb     [0:TAIL_BYTES-1];
    logic              blk_done;

    always_comb
    begin
        blk_done  = byte_valid && (fill_reg == LAST_SLOT);
        len_next  = len_reg + 32'(byte_valid);
        fill_next = blk_done ? '0 : fill_reg + FILL_W'(byte_valid);
        for (int i = 0; i < TAIL_BYTES; i++)
        begin
            merged[i] = (byte_valid && fill_reg == FILL_W'(i)) ? key_byte : buf_reg[i];
            tb[i]     = (FILL_W'(i) < fill_next) ? merged[i] : 8'h00;
        end

        info.blk_done = blk_done;
        info.blk.a    = {merged[3], merged[2], merged[1], merged[0]};
        info.blk.b    = {merged[7], merged[6], merged[5], merged[4]};
        info.blk.c    = {key_byte, merged[10], merged[9], merged[8]};
        // Low byte of the third word is kept for the length
        info.tail.a   = {tb[3], tb[2], tb[1], tb[0]};
        info.tail.b   = {tb[7], tb[6], tb[5], tb[4]};
        info.tail.c   = {tb[10], tb[9], tb[8], 8'h00} + len_next;
        info.fresh    = (fill_reg == '0) && (len_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (acc && byte_valid)
        begin
            for (int i = 0; i < TAIL_BYTES; i++)
            begin
                if (fill_reg == FILL_W'(i))
                begin
                    buf_reg[i] <= key_byte;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            len_reg  <= '0;
        end
        else if (acc)
        begin
            if (last)
            begin
                fill_reg <= '0;
                len_reg  <= '0;
            end
            else
            begin
                fill_reg <= fill_next;
                len_reg  <= len_next;
            end
        end
    end

endmodule

/* rtl/lh32_mix_pipe.sv */
// Mix pipeline: an issue register followed by one register per mixing row.
`timescale 1ns / 1ps

module lh32_mix_pipe (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              issue_vld,
    input  lh32_pkg::mix_op_t issue_op,
    output logic              out_vld,
    output lh32_pkg::mix_op_t out_op
);
    import lh32_pkg::*;

    logic    stage_vld_reg [0:MIX_ROWS];
    mix_op_t stage_reg     [0:MIX_ROWS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= MIX_ROWS; k++)
            begin
                stage_vld_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            stage_vld_reg[0] <= issue_vld;
            for (int k = 1; k <= MIX_ROWS; k++)
            begin
                stage_vld_reg[k] <= stage_vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= issue_op;
            for (int k = 1; k <= MIX_ROWS; k++)
            begin
                stage_reg[k].is_last <= stage_reg[k-1].is_last;
                stage_reg[k].w       <= mix_row(stage_reg[k-1].w, ROW_W'(k - 1));
            end
        end
    end

    assign out_vld = stage_vld_reg[MIX_ROWS];
    assign out_op  = stage_reg[MIX_ROWS];

endmodule

/* rtl/lookup2_hash_32.sv */
// Top level of the streaming lookup2 32-bit hash: control, key state and result register.
`timescale 1ns / 1ps

//  channel   direction  handshake               payload
//  -------   ---------  ---------------------   ---------------------------------
//  in        input      in_valid / in_ready     key_byte[7:0], byte_valid, last
//  out       output     out_valid / out_ready   hash_value[31:0]
//  cfg       input      cfg_wr_en (no wait)     cfg_wr_data[31:0] -> seed
//
//  One item is taken per cycle while in_ready is high. A full 12-byte block issues one
//  mix into a 10-register pipeline; a key's hash shows on out_valid after its final
//  mix leaves the pipeline. A last item arriving while the key's previous block is
//  still mixing waits in a pending register; in_ready drops until the block writes back.
//  The pipeline freezes only when a finished hash meets a full, stalled result register.
//  Reset clears control state; no clearing pass is needed.

module lookup2_hash_32 (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  key_byte,
    input  logic        byte_valid,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data
);
    import lh32_pkg::*;

    gather_t     g;
    logic        acc;
    logic        advance;
    logic        wb_now;
    logic        blk_busy;
    words_t      base;
    words_t      start_w;

    logic        issue_vld;
    mix_op_t     issue_op;
    logic        tail_vld;
    mix_op_t     tail_op;

    // Key state: the mixing words between blocks
    words_t      state_reg;
    words_t      state_next;
    logic        inflight_reg;
    logic        inflight_next;
    logic        pend_vld_reg;
    logic        pend_vld_next;
    words_t      pend_reg;
    words_t      pend_next;
    logic [31:0] seed_reg;
    logic        out_vld_reg;
    logic [31:0] hash_reg;

    lh32_gather u_gather (
        .clk        (clk),
        .rst_n      (rst_n),
        .acc        (acc),
        .key_byte   (key_byte),
        .byte_valid (byte_valid),
        .last       (last),
        .info       (g)
    );

    lh32_mix_pipe u_mix (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .issue_vld (issue_vld),
        .issue_op  (issue_op),
        .out_vld   (tail_vld),
        .out_op    (tail_op)
    );

    always_comb
    begin
        // A block mix leaving the pipeline writes back this cycle; forward it
        wb_now   = tail_vld && !tail_op.is_last;
        base     = wb_now ? tail_op.w : state_reg;
        blk_busy = inflight_reg && !wb_now;
        // Freeze only when a finished hash cannot move into the result register
        advance  = !(tail_vld && tail_op.is_last && out_vld_reg && !out_ready);
        in_ready = advance && !pend_vld_reg;
        acc      = in_valid && in_ready;

        start_w.a = GOLDEN_RATIO;
        start_w.b = GOLDEN_RATIO;
        start_w.c = seed_reg;

        issue_vld        = 1'b0;
        issue_op.is_last = 1'b0;
        issue_op.w       = base;
        inflight_next    = inflight_reg;
        pend_vld_next    = pend_vld_reg;
        pend_next        = pend_reg;
        state_next       = state_reg;

        if (advance)
        begin
            if (wb_now)
            begin
                inflight_next = 1'b0;
                if (!pend_vld_reg)
                begin
                    state_next = tail_op.w;
                end
            end

            if (pend_vld_reg && wb_now)
            begin
                // Final mix of a key that waited on its last block
                issue_vld        = 1'b1;
                issue_op.is_last = 1'b1;
                issue_op.w       = add_words(tail_op.w, pend_reg);
                pend_vld_next    = 1'b0;
            end
            else if (acc && g.blk_done)
            begin
                issue_vld     = 1'b1;
                issue_op.w    = add_words(base, g.blk);
                inflight_next = 1'b1;
                if (last)
                begin
                    pend_vld_next = 1'b1;
                    pend_next     = g.tail;
                end
            end
            else if (acc && last)
            begin
                if (blk_busy)
                begin
                    pend_vld_next = 1'b1;
                    pend_next     = g.tail;
                end
                else
                begin
                    issue_vld        = 1'b1;
                    issue_op.is_last = 1'b1;
                    issue_op.w       = add_words(base, g.tail);
                end
            end

            // Key ends: load the start words for the next key
            if (acc && last)
            begin
                state_next = start_w;
            end
        end

        // A seed written before the first byte of a key seeds that key
        if (cfg_wr_en && g.fresh)
        begin
            state_next.c = cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.a  <= GOLDEN_RATIO;
            state_reg.b  <= GOLDEN_RATIO;
            state_reg.c  <= '0;
            inflight_reg <= 1'b0;
            pend_vld_reg <= 1'b0;
            seed_reg     <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            inflight_reg <= inflight_next;
            pend_vld_reg <= pend_vld_next;
            if (cfg_wr_en)
            begin
                seed_reg <= cfg_wr_data;
            end
            if (advance && tail_vld && tail_op.is_last)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        if (advance && tail_vld && tail_op.is_last)
        begin
            hash_reg <= tail_op.w.c;
        end
    end

    assign out_valid  = out_vld_reg;
    assign hash_value = hash_reg;

    // A pending final mix always waits on a block still in the pipeline
    a_pend_has_block : assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> inflight_reg)
        else $error("pending final mix without a block in flight");

    // Blocks of one key never overlap in the pipeline
    a_one_block : assert property (@(posedge clk) disable iff (!rst_n)
        (acc && g.blk_done) |-> !inflight_reg)
        else $error("block completed while previous block still mixing");

    // A finished hash blocked by the result register is held, not dropped
    a_hold_hash : assert property (@(posedge clk) disable iff (!rst_n)
        (tail_vld && tail_op.is_last && !advance) |=> (tail_vld && $stable(tail_op.w.c)))
        else $error("finished hash lost during output stall");

    // Input is closed while a final mix is pending
    a_pend_stall : assert property (@(posedge clk) disable iff (!rst_n)
        pend_vld_reg |-> !in_ready)
        else $error("item accepted while a final mix is pending");

endmodule
